[rtl/core/hte_pkg.sv]
// Shared types and constants for the Huffman table encoder.
package hte_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_IN_W     = 8;
    localparam int SYM_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int WORK_W       = BYTE_W + CODE_W;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = Q_PTR_W + 1;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    // One queued job for the packer; code is left-aligned (first bit at MSB).
    typedef struct packed {
        logic              is_flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_qword;

    // Queue status seen by the packer.
    typedef struct packed {
        logic   empty;
        t_qword head;
    } t_qstat;

endpackage

[rtl/core/hte_front.sv]
// Front end: accepts words, owns the code table, queues encode and flush jobs.
module hte_front
    import hte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_kind,
    input  logic [SYM_IN_W-1:0] i_symbol,
    input  logic [CODE_W-1:0]   i_code_bits,
    input  logic [LEN_W-1:0]    i_code_length,
    input  logic [Q_CNT_W-1:0]  i_q_count,
    output logic                o_push,
    output t_qword              o_push_word
);

    localparam logic [SYM_IN_W:0] SYM_LIMIT = (SYM_IN_W + 1)'(SYMBOL_COUNT);

    logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_len_vld;

    logic [CODE_W-1:0] r_rd_code;
    logic [LEN_W-1:0]  r_rd_len;
    logic              r_rd_hit;
    logic              r_s1_vld;
    logic              r_s1_flush;

    logic              accept;
    logic              in_range;
    logic [SYM_W-1:0]  idx;
    logic [LEN_W-1:0]  sat_len;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  shamt;
    t_kind             kind;

    assign kind     = t_kind'(i_kind);
    assign idx      = i_symbol[SYM_W-1:0];
    assign in_range = ({1'b0, i_symbol} < SYM_LIMIT);
    assign sat_len  = (i_code_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : i_code_length;

    // Room must remain for the word now in the lookup stage.
    assign busy   = ((Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_vld))
                    >= (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept = start && !busy;

    // Table memories: write on load, registered read on every accept.
    always_ff @(posedge i_clk) begin
        if (accept && kind == KIND_LOAD && in_range) begin
            code_mem[idx] <= i_code_bits;
            len_mem[idx]  <= sat_len;
        end
        if (accept) begin
            r_rd_code <= code_mem[idx];
            r_rd_len  <= len_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld  <= '0;
            r_rd_hit   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            if (accept && kind == KIND_LOAD && in_range) begin
                r_len_vld[idx] <= 1'b1;
            end
            if (accept) begin
                r_rd_hit <= r_len_vld[idx];
            end
            r_s1_vld   <= accept && ((kind == KIND_ENCODE && in_range) || kind == KIND_FLUSH);
            r_s1_flush <= (kind == KIND_FLUSH);
        end
    end

    assign eff_len = r_rd_hit ? r_rd_len : '0;
    assign shamt   = LEN_W'(CODE_W) - eff_len;

    // Drop encodes of unloaded symbols; left-align the code bits.
    assign o_push               = r_s1_vld && (r_s1_flush || eff_len != '0);
    assign o_push_word.is_flush = r_s1_flush;
    assign o_push_word.len      = r_s1_flush ? '0 : eff_len;
    assign o_push_word.code     = r_rd_code << shamt;

endmodule

[rtl/core/hte_queue.sv]
// Short job queue between the front end and the bit packer.
module hte_queue
    import hte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_qword             i_push_word,
    input  logic               i_pop,
    output t_qstat             o_stat,
    output logic [Q_CNT_W-1:0] o_count
);

    t_qword             r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(do_pop);
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_slot[r_rd];
    assign o_count      = r_count;

endmodule

[rtl/core/hte_packer.sv]
// Back end: appends code bits to the pending byte and emits full bytes.
module hte_packer
    import hte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qstat            i_stat,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [BYTE_W-1:0] o_packed_byte,
    output logic              o_last_of_run,
    output logic [CODE_W-1:0] o_bytes_emitted
);

    // Pending bits sit left-aligned in r_work; bits below r_cnt are zero.
    logic [WORK_W-1:0] r_work;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_strobe;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [CODE_W-1:0] r_total;

    logic              draining;
    logic [WORK_W-1:0] ins;
    logic [CODE_W-1:0] total_inc;

    assign draining  = (r_cnt >= LEN_W'(BYTE_W));
    assign o_pop     = !draining && !i_stat.empty;
    assign ins       = {i_stat.head.code, {BYTE_W{1'b0}}} >> r_cnt[$clog2(BYTE_W)-1:0];
    assign total_inc = (r_total == '1) ? r_total : r_total + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_total  <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (draining) begin
                // emit one full byte a cycle
                r_strobe <= 1'b1;
                r_byte   <= r_work[WORK_W-1 -: BYTE_W];
                r_last   <= (r_cnt < LEN_W'(2 * BYTE_W));
                r_total  <= total_inc;
                r_work   <= r_work << BYTE_W;
                r_cnt    <= r_cnt - LEN_W'(BYTE_W);
            end else if (o_pop) begin
                if (i_stat.head.is_flush) begin
                    if (r_cnt != '0) begin
                        r_strobe <= 1'b1;
                        r_byte   <= r_work[WORK_W-1 -: BYTE_W];
                        r_last   <= 1'b1;
                        r_total  <= total_inc;
                    end
                    r_work <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_work <= r_work | ins;
                    r_cnt  <= r_cnt + i_stat.head.len;
                end
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_packed_byte   = r_byte;
    assign o_last_of_run   = r_last;
    assign o_bytes_emitted = r_total;

endmodule

[rtl/core/huffman_table_encoder_top.sv]
// Top level of the Huffman table encoder with bit packer.
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------
//  input     start & !busy             i_kind, i_symbol, i_code_bits, i_code_length
//  result    o_strobe (one cycle)      o_packed_byte, o_last_of_run, o_bytes_emitted
//
// A load writes the code table and queues no job. An encode passes through the
// front end (registered table read, then align) and the job queue to the packer,
// which completes N bytes (0 to 4) and drains them at one byte a cycle; this drain
// sets the sustained rate, and the packer takes no new job while it drains.
// A flush puts its byte on the result ports in the cycle after it leaves the queue.
// Reset is synchronous: it clears the table valid bits, queue, pending bits and
// byte count. busy rises while the four-entry job queue has no room; the
// receiver cannot stall, so bytes leave as soon as they are packed.
module huffman_table_encoder_top
    import hte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_kind,
    input  logic [SYM_IN_W-1:0] i_symbol,
    input  logic [CODE_W-1:0]   i_code_bits,
    input  logic [LEN_W-1:0]    i_code_length,
    output logic                o_strobe,
    output logic [BYTE_W-1:0]   o_packed_byte,
    output logic                o_last_of_run,
    output logic [CODE_W-1:0]   o_bytes_emitted
);

    logic               push;
    t_qword             push_word;
    logic               pop;
    t_qstat             q_stat;
    logic [Q_CNT_W-1:0] q_count;

    // Front: accept the word, update or read the code table, queue the job.
    hte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_push_word   (push_word)
    );

    // Hold jobs until the packer is ready for them.
    hte_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_stat      (q_stat),
        .o_count     (q_count)
    );

    // Back: pack code bits and drain full bytes one per cycle.
    hte_packer u_packer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (q_stat),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_packed_byte   (o_packed_byte),
        .o_last_of_run   (o_last_of_run),
        .o_bytes_emitted (o_bytes_emitted)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count < Q_CNT_W'(Q_DEPTH)))
        else $error("job queue overflow");

    // A run of bytes is contiguous until its last byte.
    a_run_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_of_run) |=> o_strobe)
        else $error("byte run broken before its last byte");

    // The byte count moves only with an emitted byte.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_bytes_emitted != $past(o_bytes_emitted))) |-> o_strobe)
        else $error("byte count changed without a byte");

    // An emitted byte always has a nonzero count.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bytes_emitted != '0))
        else $error("byte emitted with zero count");

endmodule

[test/testbench.sv]
// Self-checking testbench for the Huffman table encoder: directed rows, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hte_pkg::*;

    // Kind code the block ignores; the package enum leaves it out.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 195;
    localparam int POOL_SIZE    = 16;
    localparam int DRAIN_CYCLES = 40;

    // One packed output byte as the receiver sees it.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic [CODE_W-1:0] count;
    } t_byte_out;

    // One row of the directed stimulus; typed rows carry their single expected byte.
    typedef struct packed {
        logic [1:0]          kind;
        logic [SYM_IN_W-1:0] sym;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
        logic                typed;
        logic [BYTE_W-1:0]   exp_byte;
        logic [CODE_W-1:0]   exp_count;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_kind;
    logic [SYM_IN_W-1:0] i_symbol;
    logic [CODE_W-1:0]   i_code_bits;
    logic [LEN_W-1:0]    i_code_length;
    logic                o_strobe;
    logic [BYTE_W-1:0]   o_packed_byte;
    logic                o_last_of_run;
    logic [CODE_W-1:0]   o_bytes_emitted;

    huffman_table_encoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_symbol        (i_symbol),
        .i_code_bits     (i_code_bits),
        .i_code_length   (i_code_length),
        .o_strobe        (o_strobe),
        .o_packed_byte   (o_packed_byte),
        .o_last_of_run   (o_last_of_run),
        .o_bytes_emitted (o_bytes_emitted)
    );

    // Predictor state: the code table, the pending bits and the byte count.
    logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
    logic [BYTE_W-1:0] pend_bits;
    int                pend_cnt;
    logic [CODE_W-1:0] byte_total;

    // Bytes produced by the word just accepted, before they join the queue.
    t_byte_out fresh [4];
    int        fresh_n;

    // Bytes the block still owes, oldest first.
    t_byte_out awaited_bytes [$];

    // Typed expectation that goes with the word on the input ports.
    logic              cur_typed;
    logic [BYTE_W-1:0] cur_exp_byte;
    logic [CODE_W-1:0] cur_exp_count;

    int        fail_count;
    int        idle_pct;
    t_stim_row directed_rows [25];
    logic [SYM_IN_W-1:0] alphabet [POOL_SIZE];

    // Free-running clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or stops answering.
    initial begin
        #200us;
        $display("RESULT: ERROR");
        $finish;
    end

    // Emit the pending byte: bump the saturating count and clear the buffer.
    function automatic void emit_pending();
        if (byte_total != '1) begin
            byte_total = byte_total + 1;
        end
        fresh[fresh_n] = '{value: pend_bits, last: 1'b0, count: byte_total};
        fresh_n++;
        pend_bits = '0;
        pend_cnt  = 0;
    endfunction

    // Apply one word to the predictor and collect the bytes it completes in fresh[].
    function automatic void advance_packer(logic [1:0] kind, logic [SYM_IN_W-1:0] sym,
                                           logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
        int l;
        fresh_n = 0;
        case (kind)
            KIND_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    code_tbl[sym] = code;
                    len_tbl[sym]  = (len > CODE_CAP) ? LEN_W'(CODE_CAP) : len;
                end
            end
            KIND_ENCODE: begin
                if (sym < SYMBOL_COUNT) begin
                    // Walk the code from its first bit down, filling the byte from the MSB.
                    for (l = int'(len_tbl[sym]) - 1; l >= 0; l--) begin
                        pend_bits[BYTE_W - 1 - pend_cnt] = code_tbl[sym][l];
                        pend_cnt++;
                        if (pend_cnt == BYTE_W) begin
                            emit_pending();
                        end
                    end
                end
            end
            KIND_FLUSH: begin
                if (pend_cnt != 0) begin
                    emit_pending();
                end
            end
            default: ;
        endcase
        if (fresh_n > 0) begin
            fresh[fresh_n - 1].last = 1'b1;
        end
    endfunction

    // Watch both channels at the rising edge: predict on each accepted word,
    // then compare any strobed byte against the oldest one still owed.
    always @(posedge i_clk) begin
        t_byte_out want;
        int        k;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            advance_packer(i_kind, i_symbol, i_code_bits, i_code_length);
            if (cur_typed) begin
                fresh[0] = '{value: cur_exp_byte, last: 1'b1, count: cur_exp_count};
                fresh_n  = 1;
            end
            for (k = 0; k < fresh_n; k++) begin
                awaited_bytes = {awaited_bytes, fresh[k]};
            end
        end
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (awaited_bytes.size() == 0) begin
                $error("unexpected byte %h (last %b, count %0d)",
                       o_packed_byte, o_last_of_run, o_bytes_emitted);
                fail_count++;
            end else begin
                want = awaited_bytes.pop_front();
                if (o_packed_byte !== want.value) begin
                    $error("packed_byte: expected %h, got %h", want.value, o_packed_byte);
                    fail_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, o_last_of_run);
                    fail_count++;
                end
                if (o_bytes_emitted !== want.count) begin
                    $error("bytes_emitted: expected %0d, got %0d",
                           want.count, o_bytes_emitted);
                    fail_count++;
                end
            end
        end
    end

    // Present one word at the falling edge, hold it until accepted,
    // then idle cycle by cycle now and then.
    task automatic send_word(logic [1:0] kind, logic [SYM_IN_W-1:0] sym,
                             logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                             logic typed, logic [BYTE_W-1:0] exp_byte,
                             logic [CODE_W-1:0] exp_count);
        i_kind        = kind;
        i_symbol      = sym;
        i_code_bits   = code;
        i_code_length = len;
        cur_typed     = typed;
        cur_exp_byte  = exp_byte;
        cur_exp_count = exp_count;
        start         = 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Mostly short codes, some long ones, a few empty or overlong lengths.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 10) return LEN_W'($urandom_range(33, 63));
        if (r < 20) return LEN_W'($urandom_range(17, 32));
        return LEN_W'($urandom_range(1, 12));
    endfunction

    initial begin
        int                  i;
        int                  r;
        logic [SYM_IN_W-1:0] sym;

        fail_count    = 0;
        idle_pct      = 38;
        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_kind        = KIND_LOAD;
        i_symbol      = '0;
        i_code_bits   = '0;
        i_code_length = '0;
        cur_typed     = 1'b0;
        cur_exp_byte  = '0;
        cur_exp_count = '0;

        // Predictor reset: empty table, empty buffer, zero count.
        for (i = 0; i < SYMBOL_COUNT; i++) begin
            code_tbl[i] = '0;
            len_tbl[i]  = '0;
        end
        pend_bits  = '0;
        pend_cnt   = 0;
        byte_total = '0;

        // Directed rows: reset state, extremes, and each corner of the packer.
        directed_rows = '{
            // unloaded symbol right after reset emits nothing
            '{KIND_ENCODE, 8'h00, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            // flush with nothing pending
            '{KIND_FLUSH,  8'h00, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            // unused kind with every field at its top
            '{KIND_UNUSED, 8'hFF, 32'hFFFFFFFF, 6'd63, 1'b0, 8'h00, 32'd0},
            '{KIND_LOAD,   8'hFF, 32'hFFFFFFFF, 6'd8,  1'b0, 8'h00, 32'd0},
            // exactly one full byte of ones
            '{KIND_ENCODE, 8'hFF, 32'h0,        6'd0,  1'b1, 8'hFF, 32'd1},
            // full-length all-zero code: four bytes at once
            '{KIND_LOAD,   8'h00, 32'h0,        6'd32, 1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h00, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_LOAD,   8'h01, 32'h1,        6'd1,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h01, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            // single pending one, padded with zeros
            '{KIND_FLUSH,  8'h00, 32'h0,        6'd0,  1'b1, 8'h80, 32'd6},
            // overlong length clamps to the code width
            '{KIND_LOAD,   8'h80, 32'hFFFFFFFF, 6'd63, 1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h01, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h80, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_FLUSH,  8'h00, 32'h0,        6'd0,  1'b1, 8'h80, 32'd11},
            // reload with length zero removes the code
            '{KIND_LOAD,   8'h80, 32'hA5A5A5A5, 6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h80, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_LOAD,   8'h7F, 32'hAAAAAAAA, 6'd33, 1'b0, 8'h00, 32'd0},
            '{KIND_LOAD,   8'h55, 32'h5,        6'd3,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h55, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            // unused kind and a load while bits are pending leave them alone
            '{KIND_UNUSED, 8'h55, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h55, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_LOAD,   8'h10, 32'h3,        6'd2,  1'b0, 8'h00, 32'd0},
            '{KIND_ENCODE, 8'h55, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            // long code on top of a pending bit: maximum burst
            '{KIND_ENCODE, 8'h7F, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0},
            '{KIND_FLUSH,  8'h00, 32'h0,        6'd0,  1'b0, 8'h00, 32'd0}
        };

        // Hold reset, then release it at a falling edge.
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            send_word(directed_rows[n].kind, directed_rows[n].sym, directed_rows[n].code,
                      directed_rows[n].len, directed_rows[n].typed,
                      directed_rows[n].exp_byte, directed_rows[n].exp_count);
        end

        // Random part works on a small alphabet so most encodes hit loaded entries.
        for (i = 0; i < POOL_SIZE; i++) begin
            alphabet[i] = SYM_IN_W'($urandom_range(0, 255));
            send_word(KIND_LOAD, alphabet[i], $urandom, pick_length(), 1'b0, '0, '0);
        end

        for (i = 0; i < RANDOM_WORDS - POOL_SIZE; i++) begin
            // Back-to-back stretch with no idle cycles at all.
            idle_pct = (i >= 90 && i < 150) ? 0 : 38;
            r = $urandom_range(0, 99);
            sym = ($urandom_range(0, 9) != 0) ? alphabet[$urandom_range(0, POOL_SIZE - 1)]
                                              : SYM_IN_W'($urandom_range(0, 255));
            if (r < 18) begin
                send_word(KIND_LOAD, sym, $urandom, pick_length(), 1'b0, '0, '0);
            end else if (r < 80) begin
                // Encodes carry noise in the unused fields.
                send_word(KIND_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)),
                          1'b0, '0, '0);
            end else if (r < 95) begin
                send_word(KIND_FLUSH, sym, $urandom, LEN_W'($urandom_range(0, 63)),
                          1'b0, '0, '0);
            end else begin
                send_word(KIND_UNUSED, sym, $urandom, LEN_W'($urandom_range(0, 63)),
                          1'b0, '0, '0);
            end
        end

        // Drain: drop start, wait for every owed byte, then watch for strays.
        start = 1'b0;
        while (awaited_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
